// ----- rtl/ese_pkg.sv -----
// Shared types, codes and constants for the escape sequence expander.
// Used by every module of the block; depends on nothing else.
package ese_pkg;

    // Depth of the command queue between the front and back parts.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Largest code point that UTF-8 can carry.
    localparam logic [31:0] MAX_CODE_POINT = 32'h0010_FFFF;

    // Hex digit counts for the three hex escape forms.
    localparam logic [3:0] DIGITS_X     = 4'd2;
    localparam logic [3:0] DIGITS_U     = 4'd4;
    localparam logic [3:0] DIGITS_BIG_U = 4'd8;

    // Characters that the parser recognises.
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
    localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
    localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
    localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
    localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
    localparam logic [7:0] CHAR_UPPER_U   = 8'h55;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_RETURN    = 8'h0D;
    localparam logic [7:0] CHAR_TAB       = 8'h09;

    // Result status codes.
    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_BROKEN_END = 3'd1;
    localparam logic [2:0] STATUS_BAD_HEX    = 3'd2;
    localparam logic [2:0] STATUS_BAD_CODE   = 3'd3;
    localparam logic [2:0] STATUS_UNKNOWN    = 3'd4;

    // Parser state.
    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_HEX,
        MODE_DROP
    } parse_mode_t;

    // Which hex escape is being gathered.
    typedef enum logic [1:0] {
        FORM_X,
        FORM_U,
        FORM_BIG_U
    } hex_form_t;

    // Kind of work that one input word leaves for the back part.
    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_UTF8,
        CMD_ERROR
    } cmd_kind_t;

    // One queued command: a raw byte, a code point or an error status.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [20:0] value;
        logic        string_end;
    } cmd_t;

    // Input word.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_last;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       run_last;
        logic       string_end;
    } out_word_t;

endpackage

// ----- rtl/escape_sequence_expander_unit.sv -----
// Escape sequence expander: unescapes a byte string and encodes \u and \U as UTF-8.
// An accepted word is registered in a queue slot, then in the output register, as a result word.
// Throughput: one input word a cycle while the queue is not full; a word that gives a multi-byte
// UTF-8 sequence holds the output sequencer for all its bytes (up to four), absorbed by the queue.
// Reset clears parser state, queue pointers and the output valid flag; no clearing pass.
// Depends on ese_pkg, ese_front, ese_queue and ese_back.
module escape_sequence_expander_unit
    import ese_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  in_word_t  src_word,
    output logic      dst_valid,
    input  logic      dst_ready,
    output out_word_t dst_word
);

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    // Input words are taken whenever the queue has a free slot.
    assign src_ready = !full;
    assign accept    = src_valid && src_ready;

    ese_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .word   (src_word),
        .push   (push),
        .cmd    (push_cmd)
    );

    ese_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    ese_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .dst_valid  (dst_valid),
        .dst_ready  (dst_ready),
        .dst_word   (dst_word)
    );

endmodule

// ----- rtl/ese_front.sv -----
// Front part: accepts input words, runs the escape parser and queues commands.
// Depends on ese_pkg.
module ese_front
    import ese_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_word_t word,
    output logic     push,
    output cmd_t     cmd
);

    parse_mode_t mode_reg, mode_next;
    logic [3:0]  digits_reg, digits_next;
    hex_form_t   form_reg, form_next;
    logic [31:0] code_reg, code_next;

    logic       hex_ok;
    logic [3:0] hex_value;
    logic [2:0] err;

    // Hex digit decode of the incoming byte.
    always_comb
    begin
        hex_ok    = 1'b1;
        hex_value = 4'd0;
        if (word.in_byte >= 8'h30 && word.in_byte <= 8'h39) begin
            hex_value = word.in_byte[3:0];
        end
        else if ((word.in_byte >= 8'h61 && word.in_byte <= 8'h66) ||
                 (word.in_byte >= 8'h41 && word.in_byte <= 8'h46)) begin
            hex_value = word.in_byte[3:0] + 4'd9;
        end
        else begin
            hex_ok = 1'b0;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_NORMAL;
            digits_reg <= 4'd0;
            form_reg   <= FORM_X;
            code_reg   <= 32'd0;
        end
        else begin
            mode_reg   <= mode_next;
            digits_reg <= digits_next;
            form_reg   <= form_next;
            code_reg   <= code_next;
        end
    end

    // Next state and the command that each accepted word leaves behind.
    always_comb
    begin
        mode_next      = mode_reg;
        digits_next    = digits_reg;
        form_next      = form_reg;
        code_next      = code_reg;
        err            = STATUS_OK;
        push           = 1'b0;
        cmd.kind       = CMD_BYTE;
        cmd.value      = {13'd0, word.in_byte};
        cmd.string_end = word.string_last;

        if (accept) begin
            unique case (mode_reg)
                MODE_NORMAL:
                begin
                    if (word.in_byte == CHAR_BACKSLASH) begin
                        mode_next = MODE_ESCAPE;
                    end
                    else begin
                        push = 1'b1;
                    end
                end
                MODE_ESCAPE:
                begin
                    mode_next = MODE_NORMAL;
                    unique case (word.in_byte) inside
                        CHAR_BACKSLASH, CHAR_QUOTE:
                        begin
                            push = 1'b1;
                        end
                        CHAR_LOWER_N:
                        begin
                            push      = 1'b1;
                            cmd.value = {13'd0, CHAR_NEWLINE};
                        end
                        CHAR_LOWER_R:
                        begin
                            push      = 1'b1;
                            cmd.value = {13'd0, CHAR_RETURN};
                        end
                        CHAR_LOWER_T:
                        begin
                            push      = 1'b1;
                            cmd.value = {13'd0, CHAR_TAB};
                        end
                        CHAR_LOWER_X:
                        begin
                            form_next   = FORM_X;
                            digits_next = DIGITS_X;
                            code_next   = 32'd0;
                            mode_next   = MODE_HEX;
                        end
                        CHAR_LOWER_U:
                        begin
                            form_next   = FORM_U;
                            digits_next = DIGITS_U;
                            code_next   = 32'd0;
                            mode_next   = MODE_HEX;
                        end
                        CHAR_UPPER_U:
                        begin
                            form_next   = FORM_BIG_U;
                            digits_next = DIGITS_BIG_U;
                            code_next   = 32'd0;
                            mode_next   = MODE_HEX;
                        end
                        default:
                        begin
                            err = STATUS_UNKNOWN;
                        end
                    endcase
                end
                MODE_HEX:
                begin
                    if (!hex_ok) begin
                        err = STATUS_BAD_HEX;
                    end
                    else begin
                        code_next   = {code_reg[27:0], hex_value};
                        digits_next = digits_reg - 4'd1;
                        if (digits_next == 4'd0) begin
                            mode_next = MODE_NORMAL;
                            if (form_reg == FORM_X) begin
                                push      = 1'b1;
                                cmd.value = {13'd0, code_next[7:0]};
                            end
                            else if (code_next > MAX_CODE_POINT) begin
                                err = STATUS_BAD_CODE;
                            end
                            else begin
                                push      = 1'b1;
                                cmd.kind  = CMD_UTF8;
                                cmd.value = code_next[20:0];
                            end
                        end
                    end
                end
                MODE_DROP:
                begin
                    // Bytes after an error are discarded up to the end of the string.
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                end
            endcase

            // A string that stops part-way through an escape is broken.
            if (err == STATUS_OK && word.string_last &&
                (mode_next == MODE_ESCAPE || mode_next == MODE_HEX)) begin
                err = STATUS_BROKEN_END;
            end

            // Any error replaces the normal result with a single error word.
            if (err != STATUS_OK) begin
                push      = 1'b1;
                cmd.kind  = CMD_ERROR;
                cmd.value = {18'd0, err};
                mode_next = MODE_DROP;
            end

            // The end of a string always returns the parser to pass-through.
            if (word.string_last) begin
                mode_next   = MODE_NORMAL;
                digits_next = 4'd0;
                form_next   = FORM_X;
                code_next   = 32'd0;
            end
        end
    end

endmodule

// ----- rtl/ese_queue.sv -----
// Short command queue that decouples the parser from the output sequencer.
// Depends on ese_pkg.
module ese_queue
    import ese_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // Storage slots; written only on a push.
    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/ese_back.sv -----
// Back part: turns queued commands into result words, one UTF-8 byte a cycle while not stalled.
// Depends on ese_pkg.
module ese_back
    import ese_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  cmd_t      head_cmd,
    output logic      pop,
    output logic      dst_valid,
    input  logic      dst_ready,
    output out_word_t dst_word
);

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    out_word_t  out_word_reg;

    logic [1:0] last_idx;
    logic       load;
    out_word_t  word_next;

    // Index of the final byte of the current command.
    always_comb
    begin
        last_idx = 2'd0;
        if (head_cmd.kind == CMD_UTF8) begin
            if (head_cmd.value[20:7] == '0) begin
                last_idx = 2'd0;
            end
            else if (head_cmd.value[20:11] == '0) begin
                last_idx = 2'd1;
            end
            else if (head_cmd.value[20:16] == '0) begin
                last_idx = 2'd2;
            end
            else begin
                last_idx = 2'd3;
            end
        end
    end

    // Build the next result word from the head command.
    always_comb
    begin
        word_next.status     = STATUS_OK;
        word_next.out_byte   = head_cmd.value[7:0];
        word_next.run_last   = (idx_reg == last_idx);
        word_next.string_end = head_cmd.string_end;
        unique case (head_cmd.kind)
            CMD_BYTE:
            begin
                word_next.out_byte = head_cmd.value[7:0];
            end
            CMD_ERROR:
            begin
                word_next.out_byte = 8'd0;
                word_next.status   = head_cmd.value[2:0];
            end
            CMD_UTF8:
            begin
                // Lead byte first, then continuation bytes from the high end down.
                case ({last_idx, idx_reg})
                    4'b00_00: word_next.out_byte = {1'b0, head_cmd.value[6:0]};
                    4'b01_00: word_next.out_byte = {3'b110, head_cmd.value[10:6]};
                    4'b01_01: word_next.out_byte = {2'b10, head_cmd.value[5:0]};
                    4'b10_00: word_next.out_byte = {4'b1110, head_cmd.value[15:12]};
                    4'b10_01: word_next.out_byte = {2'b10, head_cmd.value[11:6]};
                    4'b10_10: word_next.out_byte = {2'b10, head_cmd.value[5:0]};
                    4'b11_00: word_next.out_byte = {5'b11110, head_cmd.value[20:18]};
                    4'b11_01: word_next.out_byte = {2'b10, head_cmd.value[17:12]};
                    4'b11_10: word_next.out_byte = {2'b10, head_cmd.value[11:6]};
                    default:  word_next.out_byte = {2'b10, head_cmd.value[5:0]};
                endcase
            end
            default:
            begin
                word_next.out_byte = 8'd0;
            end
        endcase
    end

    // The output register takes a new word when empty or being drained.
    assign load      = head_valid && (!out_valid_reg || dst_ready);
    assign pop       = load && (idx_reg == last_idx);
    assign dst_valid = out_valid_reg;
    assign dst_word  = out_word_reg;

    // Byte index within the current command and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (load) begin
                idx_reg <= pop ? 2'd0 : idx_reg + 2'd1;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end
            else if (dst_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load) begin
            out_word_reg <= word_next;
        end
    end

endmodule
